// ===== sv/chme_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// chme_pkg
// Shared types and constants of the chained hash map engine.
// ----------------------------------------------------------------------------
package chme_pkg;

  localparam int BUCKETS_DEF  = 128;
  localparam int ENTRIES_DEF  = 256;
  localparam int KEY_BITS_DEF = 32;

  // key magnitude bits folded into the bucket remainder per cycle
  localparam int DIGIT_BITS   = 8;
  // depth of the queue between front and back, a power of two
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_PUT    = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_HASH,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_HEAD,
    B_CHAIN,
    B_EMIT
  } back_state_t;

endpackage
`default_nettype wire

// ===== sv/chme_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// chme_front
// Accepts input words, normalizes the key and works out its bucket as
// |key| mod BUCKETS, one digit of the magnitude per cycle.
// ----------------------------------------------------------------------------
module chme_front import chme_pkg::*; #(
  parameter int BUCKETS  = BUCKETS_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       mode,
  input  wire logic signed [31:0]         key,
  input  wire logic signed [31:0]         value,
  input  wire logic                       clearing,
  output logic                            push,
  input  wire logic                       q_full,
  output op_t                             push_mode,
  output logic [KEY_BITS-1:0]             push_key,
  output logic [31:0]                     push_value,
  output logic [$clog2(BUCKETS)-1:0]      push_bucket
);

  localparam int BW    = $clog2(BUCKETS);
  localparam int STEPS = (KEY_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int MAG_W = STEPS * DIGIT_BITS;
  localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;

  front_state_t          state, state_next;
  logic [63:0]           key_ext;
  logic [KEY_BITS-1:0]   nkey;
  logic [KEY_BITS-1:0]   mag;
  logic [MAG_W-1:0]      mag_sh;
  logic [BW-1:0]         rem;
  logic [BW-1:0]         rem_step;
  logic [CW-1:0]         cnt;
  op_t                   mode_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [31:0]           value_r;
  logic                  accept;

  // shift one digit into the running remainder, reducing after each bit
  function automatic logic [BW-1:0] mod_digit(input logic [BW-1:0] r_in,
                                              input logic [DIGIT_BITS-1:0] d);
    logic [BW:0] r;
    r = {1'b0, r_in};
    for (int i = DIGIT_BITS - 1; i >= 0; i--) begin
      r = {r[BW-1:0], d[i]};
      if (r >= (BW+1)'(BUCKETS)) begin
        r = r - (BW+1)'(BUCKETS);
      end
    end
    return r[BW-1:0];
  endfunction

  assign key_ext  = {{32{key[31]}}, key};
  assign nkey     = key_ext[KEY_BITS-1:0];
  // most negative key maps to 2^(KEY_BITS-1), still fits unsigned
  assign mag      = nkey[KEY_BITS-1] ? (~nkey + KEY_BITS'(1)) : nkey;
  assign rem_step = mod_digit(rem, mag_sh[MAG_W-1 -: DIGIT_BITS]);

  assign in_stall = (state != F_IDLE) || clearing;
  assign accept   = in_valid && !in_stall;
  assign push     = (state == F_PUSH) && !q_full;

  assign push_mode   = mode_r;
  assign push_key    = key_r;
  assign push_value  = value_r;
  assign push_bucket = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (accept) state_next = F_HASH;
      end
      F_HASH: begin
        if (cnt == '0) state_next = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= op_t'(mode);
      key_r   <= nkey;
      value_r <= value;
      mag_sh  <= MAG_W'(mag);
      rem     <= '0;
      cnt     <= CW'(STEPS - 1);
    end else if (state == F_HASH) begin
      rem     <= rem_step;
      mag_sh  <= mag_sh << DIGIT_BITS;
      cnt     <= cnt - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== sv/chme_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// chme_queue
// Short first-in first-out queue of hashed requests between front and back.
// ----------------------------------------------------------------------------
module chme_queue import chme_pkg::*; #(
  parameter int BUCKETS  = BUCKETS_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  output logic                            q_full,
  input  wire op_t                        push_mode,
  input  wire logic [KEY_BITS-1:0]        push_key,
  input  wire logic [31:0]                push_value,
  input  wire logic [$clog2(BUCKETS)-1:0] push_bucket,
  output logic                            q_valid,
  input  wire logic                       pop,
  output op_t                             q_mode,
  output logic [KEY_BITS-1:0]             q_key,
  output logic [31:0]                     q_value,
  output logic [$clog2(BUCKETS)-1:0]      q_bucket
);

  localparam int BW   = $clog2(BUCKETS);
  localparam int PW   = $clog2(QUEUE_DEPTH);
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  op_t                 mode_q   [QUEUE_DEPTH];
  logic [KEY_BITS-1:0] key_q    [QUEUE_DEPTH];
  logic [31:0]         value_q  [QUEUE_DEPTH];
  logic [BW-1:0]       bucket_q [QUEUE_DEPTH];
  logic [PW-1:0]       wr_ptr;
  logic [PW-1:0]       rd_ptr;
  logic [CNTW-1:0]     count;

  assign q_full   = (count == CNTW'(QUEUE_DEPTH));
  assign q_valid  = (count != '0);
  assign q_mode   = mode_q[rd_ptr];
  assign q_key    = key_q[rd_ptr];
  assign q_value  = value_q[rd_ptr];
  assign q_bucket = bucket_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mode_q[wr_ptr]   <= push_mode;
      key_q[wr_ptr]    <= push_key;
      value_q[wr_ptr]  <= push_value;
      bucket_q[wr_ptr] <= push_bucket;
    end
  end

endmodule
`default_nettype wire

// ===== sv/chme_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// chme_back
// Holds the bucket heads and the entry pool, walks one chain per request,
// updates or inserts on a put, and drives the result register.
// ----------------------------------------------------------------------------
module chme_back import chme_pkg::*; #(
  parameter int BUCKETS  = BUCKETS_DEF,
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  output logic                            clearing,
  input  wire logic                       q_valid,
  output logic                            pop,
  input  wire op_t                        q_mode,
  input  wire logic [KEY_BITS-1:0]        q_key,
  input  wire logic [31:0]                q_value,
  input  wire logic [$clog2(BUCKETS)-1:0] q_bucket,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            found,
  output logic signed [31:0]              result_value,
  output logic                            full_res
);

  localparam int BW = $clog2(BUCKETS);
  localparam int AW = $clog2(ENTRIES);
  localparam int IW = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] NULL_IDX = IW'(ENTRIES);

  logic [IW-1:0]       bucket_head [BUCKETS];
  logic [KEY_BITS-1:0] entry_key   [ENTRIES];
  logic [31:0]         entry_value [ENTRIES];
  logic [IW-1:0]       entry_next  [ENTRIES];

  back_state_t         state, state_next;
  op_t                 op_r, op_next;
  logic [KEY_BITS-1:0] key_r, key_next;
  logic [31:0]         value_r, value_next;
  logic [BW-1:0]       bkt_r, bkt_next;
  logic [AW-1:0]       cur, cur_next;
  logic [IW-1:0]       used, used_next;
  logic [BW-1:0]       clr_cnt, clr_cnt_next;
  logic                res_found, res_found_next;
  logic [31:0]         res_value, res_value_next;
  logic                res_full, res_full_next;

  logic [IW-1:0]       head_q;
  logic [KEY_BITS-1:0] ek_q;
  logic [31:0]         ev_q;
  logic [IW-1:0]       en_q;

  logic                head_we, head_re;
  logic [BW-1:0]       head_wa, head_ra;
  logic [IW-1:0]       head_wd;
  logic                link_we;
  logic [AW-1:0]       link_wa;
  logic [KEY_BITS-1:0] link_key;
  logic [IW-1:0]       link_next;
  logic                val_we;
  logic [AW-1:0]       val_wa;
  logic [31:0]         val_wd;
  logic                ent_re;
  logic [AW-1:0]       ent_ra;
  logic                hit, miss, load_out;

  assign clearing = (state == B_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_CLEAR;
      clr_cnt <= '0;
      used    <= '0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
      used    <= used_next;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_next;
    key_r     <= key_next;
    value_r   <= value_next;
    bkt_r     <= bkt_next;
    cur       <= cur_next;
    res_found <= res_found_next;
    res_value <= res_value_next;
    res_full  <= res_full_next;
  end

  always_comb begin
    state_next     = state;
    op_next        = op_r;
    key_next       = key_r;
    value_next     = value_r;
    bkt_next       = bkt_r;
    cur_next       = cur;
    used_next      = used;
    clr_cnt_next   = clr_cnt;
    res_found_next = res_found;
    res_value_next = res_value;
    res_full_next  = res_full;
    head_we   = 1'b0;
    head_wa   = bkt_r;
    head_wd   = used;
    head_re   = 1'b0;
    head_ra   = q_bucket;
    link_we   = 1'b0;
    link_wa   = used[AW-1:0];
    link_key  = key_r;
    link_next = head_q;
    val_we    = 1'b0;
    val_wa    = cur;
    val_wd    = value_r;
    ent_re    = 1'b0;
    ent_ra    = head_q[AW-1:0];
    pop       = 1'b0;
    load_out  = 1'b0;
    hit       = 1'b0;
    miss      = 1'b0;

    unique case (state)
      B_CLEAR: begin
        head_we      = 1'b1;
        head_wa      = clr_cnt;
        head_wd      = NULL_IDX;
        clr_cnt_next = clr_cnt + 1'b1;
        if (clr_cnt == BW'(BUCKETS - 1)) state_next = B_IDLE;
      end
      B_IDLE: begin
        if (q_valid) begin
          pop        = 1'b1;
          head_re    = 1'b1;
          op_next    = q_mode;
          key_next   = q_key;
          value_next = q_value;
          bkt_next   = q_bucket;
          state_next = B_HEAD;
        end
      end
      B_HEAD: begin
        if (head_q == NULL_IDX) begin
          miss = 1'b1;
        end else begin
          ent_re     = 1'b1;
          ent_ra     = head_q[AW-1:0];
          cur_next   = head_q[AW-1:0];
          state_next = B_CHAIN;
        end
      end
      B_CHAIN: begin
        if (ek_q == key_r) begin
          hit = 1'b1;
        end else if (en_q == NULL_IDX) begin
          miss = 1'b1;
        end else begin
          ent_re   = 1'b1;
          ent_ra   = en_q[AW-1:0];
          cur_next = en_q[AW-1:0];
        end
      end
      B_EMIT: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_CLEAR;
    endcase

    if (hit) begin
      res_found_next = 1'b1;
      res_full_next  = 1'b0;
      state_next     = B_EMIT;
      if (op_r == OP_LOOKUP) begin
        res_value_next = ev_q;
      end else begin
        res_value_next = value_r;
        val_we         = 1'b1;
        val_wa         = cur;
      end
    end

    if (miss) begin
      res_found_next = 1'b0;
      res_full_next  = 1'b0;
      res_value_next = value_r;
      state_next     = B_EMIT;
      if (op_r == OP_LOOKUP) begin
        res_value_next = MISS_VALUE;
      end else if (used == NULL_IDX) begin
        // pool exhausted, nothing stored
        res_full_next = 1'b1;
      end else begin
        // new entry becomes the chain head
        link_we   = 1'b1;
        val_we    = 1'b1;
        val_wa    = used[AW-1:0];
        head_we   = 1'b1;
        head_wa   = bkt_r;
        head_wd   = used;
        used_next = used + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (head_we) bucket_head[head_wa] <= head_wd;
    if (head_re) head_q <= bucket_head[head_ra];
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      entry_key[link_wa]  <= link_key;
      entry_next[link_wa] <= link_next;
    end
    if (val_we) entry_value[val_wa] <= val_wd;
    if (ent_re) begin
      ek_q <= entry_key[ent_ra];
      ev_q <= entry_value[ent_ra];
      en_q <= entry_next[ent_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      found        <= res_found;
      result_value <= res_value;
      full_res     <= res_full;
    end
  end

endmodule
`default_nettype wire

// ===== sv/chained_hash_map_engine_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// chained_hash_map_engine_unit
// Integer-key hash table with separate chaining: lookups and puts, one
// result word per request word.
//
// Input channel (in_valid / in_stall) carries mode, key and value; output
// channel (out_valid / out_stall) carries found, result_value and full_res.
// A lookup miss returns -1; a put echoes its value, and full_res flags a put
// of a new key once all ENTRIES pool slots are taken.
// The front takes one word at a time and keeps in_stall high until it has
// hashed it, folding 8 key bits per cycle, and pushed it into the queue.
// The back visits chain entries one at a time, as the entry pool has a
// single read port. A two-deep queue sits between them.
// With an empty queue and no stall, a taken word passes through the front's
// hash, the queue, the back's head read and chain walk, then out_valid rises.
// After reset the bucket heads are swept empty, one per cycle; in_stall is
// high meanwhile. A stalled result holds in the output register while the
// front and the queue keep taking words until the queue is full.
// ----------------------------------------------------------------------------
module chained_hash_map_engine_unit import chme_pkg::*; #(
  parameter int BUCKETS  = BUCKETS_DEF,
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               mode,
  input  wire logic signed [31:0] key,
  input  wire logic signed [31:0] value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    found,
  output logic signed [31:0]      result_value,
  output logic                    full_res
);

  localparam int BW = $clog2(BUCKETS);

  logic                clearing;
  logic                push, q_full, q_valid, pop;
  op_t                 push_mode, q_mode;
  logic [KEY_BITS-1:0] push_key, q_key;
  logic [31:0]         push_value, q_value;
  logic [BW-1:0]       push_bucket, q_bucket;

  chme_front #(
    .BUCKETS  (BUCKETS),
    .KEY_BITS (KEY_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .key         (key),
    .value       (value),
    .clearing    (clearing),
    .push        (push),
    .q_full      (q_full),
    .push_mode   (push_mode),
    .push_key    (push_key),
    .push_value  (push_value),
    .push_bucket (push_bucket)
  );

  chme_queue #(
    .BUCKETS  (BUCKETS),
    .KEY_BITS (KEY_BITS)
  ) u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .q_full      (q_full),
    .push_mode   (push_mode),
    .push_key    (push_key),
    .push_value  (push_value),
    .push_bucket (push_bucket),
    .q_valid     (q_valid),
    .pop         (pop),
    .q_mode      (q_mode),
    .q_key       (q_key),
    .q_value     (q_value),
    .q_bucket    (q_bucket)
  );

  chme_back #(
    .BUCKETS  (BUCKETS),
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .clearing     (clearing),
    .q_valid      (q_valid),
    .pop          (pop),
    .q_mode       (q_mode),
    .q_key        (q_key),
    .q_value      (q_value),
    .q_bucket     (q_bucket),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .found        (found),
    .result_value (result_value),
    .full_res     (full_res)
  );

endmodule
`default_nettype wire

// ===== tb/chained_hash_map_engine_unit_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// chained_hash_map_engine_unit_test
// Self-checking bench for the chained hash map engine. Directed words cover
// the key extremes, bucket collisions, sign pairs and overwrites. Random
// words then grow the chains of a few hot buckets until the entry pool runs
// out, and go on past that point. Expected results come from a table model
// kept in the bench, and both channels idle and stall at random.
// ----------------------------------------------------------------------------
module chained_hash_map_engine_unit_test import chme_pkg::*;;

  localparam int NULL_IDX     = ENTRIES_DEF;
  localparam int RANDOM_WORDS = 1700;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 64;

  typedef struct {
    op_t                op;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } map_req_t;

  typedef struct {
    logic               found;
    logic signed [31:0] value;
    logic               full;
  } map_rsp_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               req_mode = OP_LOOKUP;
  logic signed [31:0] req_key = '0;
  logic signed [31:0] req_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               rsp_found;
  logic signed [31:0] rsp_value;
  logic               rsp_full;

  chained_hash_map_engine_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (req_mode),
    .key          (req_key),
    .value        (req_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .found        (rsp_found),
    .result_value (rsp_value),
    .full_res     (rsp_full)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // table model
  int                 chain_head [BUCKETS_DEF];
  logic signed [31:0] slot_key   [ENTRIES_DEF];
  logic signed [31:0] slot_value [ENTRIES_DEF];
  int                 slot_next  [ENTRIES_DEF];
  int                 slots_used;

  map_req_t           pending_words [$];
  map_rsp_t           expected_results [$];
  logic signed [31:0] known_keys [$];

  int total_words;
  int words_taken;
  int results_seen;
  int error_count;
  int idle_cycles;
  int lookup_hits, lookup_misses, new_puts, overwrites, pool_rejects, longest_chain;
  bit word_taken;

  function automatic map_rsp_t apply_request(map_req_t req);
    logic [32:0] mag;
    int          bkt;
    int          idx;
    int          hit;
    int          depth;
    map_rsp_t    rsp;
    // magnitude in 33 bits so the most negative key does not overflow
    mag = req.key[31] ? ({1'b0, ~req.key} + 33'd1) : {1'b0, req.key};
    bkt = int'(mag % BUCKETS_DEF);
    idx = chain_head[bkt];
    hit = NULL_IDX;
    depth = 0;
    while (idx != NULL_IDX && hit == NULL_IDX) begin
      depth++;
      if (slot_key[idx] == req.key) hit = idx;
      else idx = slot_next[idx];
    end
    if (depth > longest_chain) longest_chain = depth;
    rsp.found = (hit != NULL_IDX);
    rsp.value = req.value;
    rsp.full  = 1'b0;
    if (req.op == OP_LOOKUP) begin
      rsp.value = rsp.found ? slot_value[hit] : MISS_VALUE;
      if (rsp.found) lookup_hits++;
      else lookup_misses++;
    end else if (rsp.found) begin
      slot_value[hit] = req.value;
      overwrites++;
    end else if (slots_used >= ENTRIES_DEF) begin
      rsp.full = 1'b1;
      pool_rejects++;
    end else begin
      slot_key[slots_used]   = req.key;
      slot_value[slots_used] = req.value;
      slot_next[slots_used]  = chain_head[bkt];
      chain_head[bkt]        = slots_used;
      slots_used++;
      new_puts++;
    end
    return rsp;
  endfunction

  task automatic queue_word(op_t op, logic signed [31:0] k, logic signed [31:0] v);
    map_req_t req;
    req.op    = op;
    req.key   = k;
    req.value = v;
    pending_words.push_back(req);
  endtask

  // new keys: half fully random, half packed into 16 hot buckets to build chains
  function automatic logic signed [31:0] fresh_key();
    logic signed [31:0] k;
    if ($urandom_range(0, 1)) begin
      k = $urandom;
    end else begin
      k = $urandom_range(0, 15) * 8 + 3 + 128 * $urandom_range(0, 16000000);
      if ($urandom_range(0, 1)) k = -k;
    end
    return k;
  endfunction

  task automatic queue_random_words();
    logic signed [31:0] k;
    op_t                op;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      op = ($urandom_range(0, 9) < 6) ? OP_PUT : OP_LOOKUP;
      if (known_keys.size() == 0 || $urandom_range(0, 9) < 4) k = fresh_key();
      else k = known_keys[$urandom_range(0, known_keys.size() - 1)];
      if (op == OP_PUT) known_keys.push_back(k);
      queue_word(op, k, $urandom);
    end
  endtask

  // input side: capture accepted words and predict their results
  always @(posedge clk) begin
    word_taken = !rst && in_valid && !in_stall;
    if (word_taken) begin
      expected_results.push_back(apply_request('{op_t'(req_mode), req_key, req_value}));
      words_taken++;
    end
  end

  // driver: bursts of words separated by random gaps
  int       burst_left = 0;
  int       gap_left = 0;
  map_req_t next_word;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !word_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        next_word = pending_words.pop_front();
        req_mode  <= next_word.op;
        req_key   <= next_word.key;
        req_value <= next_word.value;
        in_valid  <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall: off, coin flip, or long runs, switching every so often
  int   stall_style = 0;
  int   style_left = 0;
  int   run_left = 0;
  logic stall_next;

  always @(negedge clk) begin
    if (style_left == 0) begin
      stall_style = $urandom_range(0, 2);
      style_left  = $urandom_range(32, 256);
    end
    style_left--;
    stall_next = 1'b0;
    case (stall_style)
      1: begin
        stall_next = 1'($urandom_range(0, 1));
      end
      2: begin
        if (run_left == 0) run_left = $urandom_range(1, 20);
        run_left--;
        stall_next = (run_left == 0) ? ~out_stall : out_stall;
      end
      default: begin
        stall_next = 1'b0;
      end
    endcase
    out_stall <= stall_next;
  end

  // monitor and watchdog
  map_rsp_t want;

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
        $display("Verification failed");
        $finish;
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected: found=%0b value=%h full_res=%0b",
                 rsp_found, rsp_value, rsp_full);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (rsp_found !== want.found) begin
            $error("found: expected %0b got %0b", want.found, rsp_found);
            error_count++;
          end
          if (rsp_value !== want.value) begin
            $error("result_value: expected %h got %h", want.value, rsp_value);
            error_count++;
          end
          if (rsp_full !== want.full) begin
            $error("full_res: expected %0b got %0b", want.full, rsp_full);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    for (int b = 0; b < BUCKETS_DEF; b++) chain_head[b] = NULL_IDX;
    for (int e = 0; e < ENTRIES_DEF; e++) begin
      slot_key[e]   = '0;
      slot_value[e] = '0;
      slot_next[e]  = NULL_IDX;
    end
    slots_used = 0;

    // empty table, then bucket 0 collisions including the most negative key, and the largest key
    queue_word(OP_LOOKUP, 32'sd0, 32'h7FFF_FFFF);
    queue_word(OP_PUT, 32'sd0, 32'h8000_0000);
    queue_word(OP_PUT, 32'h8000_0000, 32'hFFFF_FFFF);
    queue_word(OP_PUT, -32'sd128, 32'h0000_0000);
    queue_word(OP_PUT, 32'sd128, 32'h0000_0001);
    queue_word(OP_PUT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    // sign pair sharing bucket 1
    queue_word(OP_PUT, -32'sd1, 32'h1234_5678);
    queue_word(OP_PUT, 32'sd1, 32'h5A5A_5A5A);
    queue_word(OP_LOOKUP, 32'h8000_0000, 32'h0000_0000);
    queue_word(OP_LOOKUP, 32'sd0, 32'hFFFF_FFFF);
    queue_word(OP_LOOKUP, -32'sd128, 32'h0000_0000);
    queue_word(OP_LOOKUP, 32'sd128, 32'h0000_0000);
    queue_word(OP_LOOKUP, -32'sd1, 32'h0000_0000);
    queue_word(OP_LOOKUP, 32'sd1, 32'h0000_0000);
    queue_word(OP_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);
    // misses in occupied buckets
    queue_word(OP_LOOKUP, 32'h8000_0001, 32'h0000_0000);
    queue_word(OP_LOOKUP, -32'sd129, 32'h0000_0000);
    queue_word(OP_LOOKUP, 32'sd256, 32'h0000_0000);
    // overwrites at chain tail and middle
    queue_word(OP_PUT, 32'sd0, 32'h0000_0000);
    queue_word(OP_LOOKUP, 32'sd0, 32'h0000_0000);
    queue_word(OP_PUT, -32'sd128, 32'hFFFF_FFFF);
    queue_word(OP_LOOKUP, -32'sd128, 32'h0000_0000);
    known_keys = '{32'sd0, 32'h8000_0000, -32'sd128, 32'sd128, 32'h7FFF_FFFF,
                   -32'sd1, 32'sd1};
    queue_random_words();
    total_words = pending_words.size();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (words_taken < total_words || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d words: %0d lookup hits, %0d misses, %0d new puts, %0d overwrites",
             total_words, lookup_hits, lookup_misses, new_puts, overwrites);
    $display("pool full rejects %0d, longest chain walked %0d, results %0d",
             pool_rejects, longest_chain, results_seen);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
